// File: hdl/irf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irf_pkg
// Shared types and constants of the multichannel iir filter core: stream
// field layout, item kinds, controller commands and datapath status.
// ----------------------------------------------------------------------------
package irf_pkg;

    localparam int COEF_FRAC = 24;

    localparam int CHAN_W   = 3;
    localparam int SMP_W    = 32;
    localparam int ORD_IN_W = 3;
    localparam int CIDX_W   = 4;
    localparam int CVAL_W   = 32;

    // input stream tdata layout
    localparam int IN_CHAN_LSB = 0;
    localparam int IN_SMP_LSB  = IN_CHAN_LSB + CHAN_W;
    localparam int IN_ORD_LSB  = IN_SMP_LSB + SMP_W;
    localparam int IN_CLR_BIT  = IN_ORD_LSB + ORD_IN_W;
    localparam int IN_CIDX_LSB = IN_CLR_BIT + 1;
    localparam int IN_CVAL_LSB = IN_CIDX_LSB + CIDX_W;
    localparam int IN_BITS     = IN_CVAL_LSB + CVAL_W;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W   = 1;

    // output stream tdata layout
    localparam int OUT_CHAN_LSB = 0;
    localparam int OUT_SMP_LSB  = OUT_CHAN_LSB + CHAN_W;
    localparam int OUT_SAT_BIT  = OUT_SMP_LSB + SMP_W;
    localparam int OUT_BITS     = OUT_SAT_BIT + 1;
    localparam int M_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_COEF   = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_INIT,
        OP_COEF,
        OP_LOAD,
        OP_ZERO,
        OP_TAP,
        OP_ROUND,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic first;
    } t_cmd;

    typedef struct packed {
        logic chan_ok;
        logic clear;
        logic pipe_empty;
        logic out_free;
    } t_status;

endpackage

// File: hdl/irf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irf_ram
// Simple dual-port ram: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module irf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/irf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irf_ctrl
// Sequencer of the filter core: clearing pass, item intake, history zero
// fill, tap issue, drain, rounding and result hand-off.
// ----------------------------------------------------------------------------
module irf_ctrl import irf_pkg::*; #(
    parameter int NUM_CHANNELS = 8,
    parameter int MAX_ORDER    = 4,
    localparam int IDX_W = $clog2(NUM_CHANNELS * (MAX_ORDER + 1)),
    localparam int ORD_W = $clog2(MAX_ORDER + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  t_mode            i_mode,
    input  t_status          i_status,
    input  logic [ORD_W-1:0] i_order,
    output logic             o_s_ready,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_idx
);

    localparam logic [IDX_W-1:0] INIT_LAST = IDX_W'(NUM_CHANNELS * (MAX_ORDER + 1) - 1);
    localparam logic [IDX_W-1:0] ZERO_LAST = IDX_W'(MAX_ORDER - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ZERO,
        ST_TAP0,
        ST_TAPS,
        ST_DRAIN,
        ST_ROUND,
        ST_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd     = '{op: OP_NOP, first: 1'b0};
        o_s_ready = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_cmd.op = OP_INIT;
                if (r_cnt == INIT_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    if (i_mode == MODE_COEF) begin
                        o_cmd.op = OP_COEF;
                    end else if (i_status.chan_ok) begin
                        o_cmd.op = OP_LOAD;
                        n_cnt    = '0;
                        n_state  = i_status.clear ? ST_ZERO : ST_TAP0;
                    end
                end
            end
            ST_ZERO: begin
                o_cmd.op = OP_ZERO;
                if (r_cnt == ZERO_LAST) begin
                    n_state = ST_TAP0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_TAP0: begin
                o_cmd.op    = OP_TAP;
                o_cmd.first = 1'b1;
                if (i_order == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt   = IDX_W'(i_order) - 1'b1;
                    n_state = ST_TAPS;
                end
            end
            ST_TAPS: begin
                o_cmd.op = OP_TAP;
                if (r_cnt == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.op = OP_ROUND;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idx = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: hdl/irf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irf_datapath
// Coefficient and history memories, input decode, two-product tap pipeline,
// wide accumulator, rounding and saturation, output register.
// ----------------------------------------------------------------------------
module irf_datapath import irf_pkg::*; #(
    parameter int NUM_CHANNELS = 8,
    parameter int MAX_ORDER    = 4,
    parameter int DATA_WIDTH   = 32,
    parameter int COEF_WIDTH   = 32,
    localparam int IDX_W = $clog2(NUM_CHANNELS * (MAX_ORDER + 1)),
    localparam int ORD_W = $clog2(MAX_ORDER + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [S_TDATA_W-1:0] i_tdata,
    output t_status              o_status,
    output logic [ORD_W-1:0]     o_order,
    output logic [M_TDATA_W-1:0] o_tdata,
    output logic                 o_tvalid,
    input  logic                 i_tready
);

    localparam int TAPS   = 2 * MAX_ORDER + 1;
    localparam int HDEPTH = NUM_CHANNELS * MAX_ORDER;
    localparam int BDEPTH = NUM_CHANNELS * (MAX_ORDER + 1);
    localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int BAW    = $clog2(BDEPTH);
    localparam int PW     = DATA_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PW + $clog2(TAPS) + 1;
    localparam int EXT_D  = (DATA_WIDTH > SMP_W) ? DATA_WIDTH : SMP_W;
    localparam int EXT_C  = (COEF_WIDTH > CVAL_W) ? COEF_WIDTH : CVAL_W;

    localparam logic signed [EXT_D-1:0] XMAX =
        {{(EXT_D - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [EXT_D-1:0] XMIN =
        {{(EXT_D - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};
    localparam logic signed [EXT_C-1:0] CMAX =
        {{(EXT_C - COEF_WIDTH + 1){1'b0}}, {(COEF_WIDTH - 1){1'b1}}};
    localparam logic signed [EXT_C-1:0] CMIN =
        {{(EXT_C - COEF_WIDTH + 1){1'b1}}, {(COEF_WIDTH - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] YMAX =
        {{(ACC_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] YMIN =
        {{(ACC_W - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] RND =
        {{(ACC_W - COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}};

    // input decode
    logic [CHAN_W-1:0]        in_chan;
    logic signed [SMP_W-1:0]  in_smp;
    logic [ORD_IN_W-1:0]      in_ord;
    logic                     in_clr;
    logic [CIDX_W-1:0]        in_cidx;
    logic signed [CVAL_W-1:0] in_cval;
    logic                     chan_ok;
    logic signed [EXT_D-1:0]  smp_ext;
    logic signed [EXT_C-1:0]  cval_ext;
    logic [DATA_WIDTH-1:0]    x_new;
    logic [COEF_WIDTH-1:0]    c_new;
    logic [ORD_W-1:0]         ord_clamp;

    assign in_chan = i_tdata[IN_CHAN_LSB +: CHAN_W];
    assign in_smp  = i_tdata[IN_SMP_LSB +: SMP_W];
    assign in_ord  = i_tdata[IN_ORD_LSB +: ORD_IN_W];
    assign in_clr  = i_tdata[IN_CLR_BIT];
    assign in_cidx = i_tdata[IN_CIDX_LSB +: CIDX_W];
    assign in_cval = i_tdata[IN_CVAL_LSB +: CVAL_W];

    assign chan_ok  = int'(in_chan) < NUM_CHANNELS;
    assign smp_ext  = EXT_D'(in_smp);
    assign cval_ext = EXT_C'(in_cval);

    always_comb begin
        if (smp_ext > XMAX) begin
            x_new = XMAX[DATA_WIDTH-1:0];
        end else if (smp_ext < XMIN) begin
            x_new = XMIN[DATA_WIDTH-1:0];
        end else begin
            x_new = smp_ext[DATA_WIDTH-1:0];
        end
        if (cval_ext > CMAX) begin
            c_new = CMAX[COEF_WIDTH-1:0];
        end else if (cval_ext < CMIN) begin
            c_new = CMIN[COEF_WIDTH-1:0];
        end else begin
            c_new = cval_ext[COEF_WIDTH-1:0];
        end
        if (int'(in_ord) > MAX_ORDER) begin
            ord_clamp = ORD_W'(MAX_ORDER);
        end else begin
            ord_clamp = ORD_W'(in_ord);
        end
    end

    // item registers
    logic [CHAN_W-1:0]            r_ch;
    logic signed [DATA_WIDTH-1:0] r_x;
    logic [ORD_W-1:0]             r_n;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_ch <= in_chan;
            r_x  <= x_new;
            r_n  <= ord_clamp;
        end
    end

    // memory ports
    logic                  b_we, a_we, h_we;
    logic [BAW-1:0]        b_waddr, b_raddr;
    logic [HAW-1:0]        a_waddr, h_waddr, h_raddr;
    logic [COEF_WIDTH-1:0] b_wdata, a_wdata, b_rd, a_rd;
    logic [DATA_WIDTH-1:0] xh_wdata, yh_wdata, xh_rd, yh_rd;

    logic                         r_v1, r_first1, r_v2;
    logic [ORD_W-1:0]             r_j1;
    logic signed [DATA_WIDTH-1:0] r_y;
    logic                         r_sat;

    assign h_raddr = HAW'(int'(r_ch) * MAX_ORDER + int'(i_idx));
    assign b_raddr = i_cmd.first ? BAW'(int'(r_ch) * (MAX_ORDER + 1)) :
                     BAW'(int'(r_ch) * (MAX_ORDER + 1) + int'(i_idx) + 1);

    always_comb begin
        b_we    = 1'b0;
        b_waddr = BAW'(int'(in_chan) * (MAX_ORDER + 1) + int'(in_cidx));
        b_wdata = c_new;
        a_we    = 1'b0;
        a_waddr = HAW'(int'(in_chan) * MAX_ORDER + int'(in_cidx) - MAX_ORDER - 1);
        a_wdata = c_new;
        case (i_cmd.op)
            OP_INIT: begin
                b_we    = 1'b1;
                b_waddr = BAW'(i_idx);
                b_wdata = '0;
                a_we    = int'(i_idx) < HDEPTH;
                a_waddr = HAW'(i_idx);
                a_wdata = '0;
            end
            OP_COEF: begin
                b_we = chan_ok && (int'(in_cidx) <= MAX_ORDER);
                a_we = chan_ok && (int'(in_cidx) > MAX_ORDER) && (int'(in_cidx) < TAPS);
            end
            default: begin
                b_we = 1'b0;
                a_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        h_we     = 1'b0;
        h_waddr  = h_raddr;
        xh_wdata = '0;
        yh_wdata = '0;
        case (i_cmd.op)
            OP_INIT: begin
                h_we    = int'(i_idx) < HDEPTH;
                h_waddr = HAW'(i_idx);
            end
            OP_ZERO: begin
                h_we = 1'b1;
            end
            OP_FINISH: begin
                h_we     = r_n != '0;
                h_waddr  = HAW'(int'(r_ch) * MAX_ORDER);
                xh_wdata = r_x;
                yh_wdata = r_y;
            end
            default: begin
                // shift one history entry down as it comes out of the ram
                if (r_v1 && !r_first1 && (int'(r_j1) + 1 < int'(r_n))) begin
                    h_we     = 1'b1;
                    h_waddr  = HAW'(int'(r_ch) * MAX_ORDER + int'(r_j1) + 1);
                    xh_wdata = xh_rd;
                    yh_wdata = yh_rd;
                end
            end
        endcase
    end

    irf_ram #(.WIDTH(COEF_WIDTH), .DEPTH(BDEPTH)) u_bram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rd)
    );

    irf_ram #(.WIDTH(COEF_WIDTH), .DEPTH(HDEPTH)) u_aram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (h_raddr),
        .o_rdata (a_rd)
    );

    irf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(HDEPTH)) u_xram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (xh_wdata),
        .i_raddr (h_raddr),
        .o_rdata (xh_rd)
    );

    irf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(HDEPTH)) u_yram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (yh_wdata),
        .i_raddr (h_raddr),
        .o_rdata (yh_rd)
    );

    // tap pipeline
    logic signed [COEF_WIDTH-1:0] b_s, a_s;
    logic signed [DATA_WIDTH-1:0] xh_s, yh_s, opx;
    logic signed [PW-1:0]         r_pb, r_pa;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [ACC_W-1:0]      rnd_sum, rnd_sh;

    assign b_s  = b_rd;
    assign a_s  = a_rd;
    assign xh_s = xh_rd;
    assign yh_s = yh_rd;
    assign opx  = r_first1 ? r_x : xh_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.op == OP_TAP;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= i_cmd.first;
        r_j1     <= ORD_W'(i_idx);
        r_pb     <= b_s * opx;
        if (r_first1) begin
            r_pa <= '0;
        end else begin
            r_pa <= a_s * yh_s;
        end
        if (i_cmd.op == OP_LOAD) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_pb) - ACC_W'(r_pa);
        end
    end

    // round half up, drop the coefficient fraction, saturate
    assign rnd_sum = r_acc + RND;
    assign rnd_sh  = rnd_sum >>> COEF_FRAC;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ROUND) begin
            if (rnd_sh > YMAX) begin
                r_y   <= YMAX[DATA_WIDTH-1:0];
                r_sat <= 1'b1;
            end else if (rnd_sh < YMIN) begin
                r_y   <= YMIN[DATA_WIDTH-1:0];
                r_sat <= 1'b1;
            end else begin
                r_y   <= rnd_sh[DATA_WIDTH-1:0];
                r_sat <= 1'b0;
            end
        end
    end

    // output register
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TDATA_W-1:0] out_word;

    always_comb begin
        out_word                             = '0;
        out_word[OUT_CHAN_LSB +: CHAN_W]     = r_ch;
        out_word[OUT_SMP_LSB +: SMP_W]       = SMP_W'(r_y);
        out_word[OUT_SAT_BIT]                = r_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FINISH) begin
            r_out_data <= out_word;
        end
    end

    assign o_tvalid            = r_out_valid;
    assign o_tdata             = r_out_data;
    assign o_order             = r_n;
    assign o_status.chan_ok    = chan_ok;
    assign o_status.clear      = in_clr;
    assign o_status.pipe_empty = !r_v1 && !r_v2;
    assign o_status.out_free   = !r_out_valid || i_tready;

endmodule

// File: hdl/multichannel_iir_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_iir_filter_core
// Multichannel direct form one iir filter with per-channel coefficient and
// history memories and one shared two-product tap pipeline.
// ----------------------------------------------------------------------------
// A sample transaction of order n (clamped to MAX_ORDER) occupies the core from
// acceptance until it can take the next transaction: the tap pipeline reads one
// b and one a coefficient with their history entries per cycle and then drains,
// rounds and hands off the result; a clear_history request first adds a history
// zero fill of MAX_ORDER entries. A coefficient write returns nothing. After
// reset the core runs a clearing pass over its memories with s_axis_tready
// low. A finished result waits in the output register while the next
// transaction is accepted.
module multichannel_iir_filter_core import irf_pkg::*; #(
    parameter int NUM_CHANNELS = 8,
    parameter int MAX_ORDER    = 4,
    parameter int DATA_WIDTH   = 32,
    parameter int COEF_WIDTH   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // channel, sample_in, filter_order, clear_history, coef_index, coef_value
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // mode
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_channel, sample_out, saturated
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(NUM_CHANNELS * (MAX_ORDER + 1));
    localparam int ORD_W = $clog2(MAX_ORDER + 1);

    t_cmd             cmd;
    t_status          status;
    logic [IDX_W-1:0] idx;
    logic [ORD_W-1:0] order;

    irf_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_ORDER    (MAX_ORDER)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_mode    (t_mode'(s_axis_tuser[0])),
        .i_status  (status),
        .i_order   (order),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd),
        .o_idx     (idx)
    );

    irf_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_ORDER    (MAX_ORDER),
        .DATA_WIDTH   (DATA_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_idx    (idx),
        .i_tdata  (s_axis_tdata),
        .o_status (status),
        .o_order  (order),
        .o_tdata  (m_axis_tdata),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready)
    );

endmodule

// File: hdl/irf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irf_checker
// Port-level checks of the filter core, bound to the top level.
// ----------------------------------------------------------------------------
module irf_checker import irf_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [S_TUSER_W-1:0] s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // reset starts the clearing pass with no result pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("core not quiet after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction dropped or changed while stalled");

    // a coefficient write never produces a result
    a_coef_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == MODE_COEF) && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result after coefficient write");

    // a new result only appears at the end of a sample, never while taking input
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while core was idle");

endmodule

bind multichannel_iir_filter_core irf_checker u_irf_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for multichannel_iir_filter_core. Streams coefficient
// writes and filter samples into the core with random gaps and output stalls.
// A built-in fixed-point predictor mirrors the per-channel coefficient and
// history memories and checks every output transaction field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import irf_pkg::*;

    localparam int NUM_CH    = 8;
    localparam int MAX_ORD   = 4;
    localparam int NUM_TAPS  = 2 * MAX_ORD + 1;
    localparam logic signed [31:0] Q24_ONE = 32'sh0100_0000;
    localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (COEF_FRAC - 1);
    localparam logic signed [127:0] Y_MAX = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] Y_MIN = -128'sh8000_0000;

    typedef struct {
        t_mode             mode;
        logic [2:0]        chan;
        logic signed [31:0] smp;
        logic [2:0]        ord;
        logic              clr;
        logic [3:0]        cidx;
        logic signed [31:0] cval;
    } t_item;

    typedef struct packed {
        logic [2:0]  chan;
        logic [31:0] smp;
        logic        sat;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    logic signed [31:0] coef_mem [NUM_CH][NUM_TAPS];
    logic signed [31:0] x_hist [NUM_CH][MAX_ORD];
    logic signed [31:0] y_hist [NUM_CH][MAX_ORD];
    t_result            expected_out[$];

    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;
    bit hold_off    = 1'b0;
    int sink_pause  = 0;
    int mismatches  = 0;
    int n_samples   = 0;
    int n_coef      = 0;
    int n_checked   = 0;
    int n_sat       = 0;

    multichannel_iir_filter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d outputs outstanding", expected_out.size());
        $display("TEST FAILED");
        $finish;
    end

    // direct form one filter step on the mirrored channel state, or a coefficient write
    function automatic void iir_predict(input t_item it);
        logic signed [127:0] acc;
        logic signed [127:0] scaled;
        t_result             res;
        int                  n;
        int                  ch;
        ch = int'(it.chan);
        if (it.mode == MODE_COEF) begin
            n_coef++;
            if (it.cidx < NUM_TAPS)
                coef_mem[ch][it.cidx] = it.cval;
            return;
        end
        n_samples++;
        n = (int'(it.ord) > MAX_ORD) ? MAX_ORD : int'(it.ord);
        if (it.clr) begin
            for (int i = 0; i < MAX_ORD; i++) begin
                x_hist[ch][i] = '0;
                y_hist[ch][i] = '0;
            end
        end
        acc = coef_mem[ch][0] * it.smp;
        for (int i = 1; i <= n; i++) begin
            acc = acc + coef_mem[ch][i] * x_hist[ch][i-1];
            acc = acc - coef_mem[ch][MAX_ORD+i] * y_hist[ch][i-1];
        end
        scaled = (acc + ROUND_HALF) >>> COEF_FRAC;
        res.chan = it.chan;
        res.sat  = 1'b1;
        if (scaled > Y_MAX)
            res.smp = Y_MAX[31:0];
        else if (scaled < Y_MIN)
            res.smp = Y_MIN[31:0];
        else begin
            res.smp = scaled[31:0];
            res.sat = 1'b0;
        end
        if (n >= 1) begin
            for (int i = n - 1; i >= 1; i--) begin
                x_hist[ch][i] = x_hist[ch][i-1];
                y_hist[ch][i] = y_hist[ch][i-1];
            end
            x_hist[ch][0] = it.smp;
            y_hist[ch][0] = res.smp;
        end
        expected_out.push_back(res);
    endfunction

    function automatic t_item mk_sample(input int ch, input logic signed [31:0] x,
                                        input int ord, input bit clr);
        t_item it;
        it.mode = MODE_SAMPLE;
        it.chan = 3'(ch);
        it.smp  = x;
        it.ord  = 3'(ord);
        it.clr  = clr;
        it.cidx = 4'($urandom_range(0, 15));
        it.cval = $urandom;
        return it;
    endfunction

    function automatic t_item mk_coef(input int ch, input int idx,
                                      input logic signed [31:0] val);
        t_item it;
        it.mode = MODE_COEF;
        it.chan = 3'(ch);
        it.smp  = $urandom;
        it.ord  = 3'($urandom_range(0, 7));
        it.clr  = 1'($urandom_range(0, 1));
        it.cidx = 4'(idx);
        it.cval = val;
        return it;
    endfunction

    task automatic send_item(input t_item it);
        int                   gap;
        int                   roll;
        logic [S_TDATA_W-1:0] word;
        gap = 0;
        if (!src_steady) begin
            roll = $urandom_range(0, 99);
            if (roll >= 92)
                gap = $urandom_range(10, 40);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word = '0;
        word[IN_CHAN_LSB +: CHAN_W]   = it.chan;
        word[IN_SMP_LSB +: SMP_W]     = it.smp;
        word[IN_ORD_LSB +: ORD_IN_W]  = it.ord;
        word[IN_CLR_BIT]              = it.clr;
        word[IN_CIDX_LSB +: CIDX_W]   = it.cidx;
        word[IN_CVAL_LSB +: CVAL_W]   = it.cval;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        iir_predict(it);
    endtask

    // output side: check each transaction, then decide next tready
    always @(posedge i_clk) begin
        int      roll;
        t_result exp_res;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.chan = m_axis_tdata[OUT_CHAN_LSB +: CHAN_W];
            got.smp  = m_axis_tdata[OUT_SMP_LSB +: SMP_W];
            got.sat  = m_axis_tdata[OUT_SAT_BIT];
            n_checked++;
            if (got.sat) n_sat++;
            if (expected_out.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected output: ch %0d y %h sat %b",
                             got.chan, got.smp, got.sat);
                mismatches++;
            end else begin
                exp_res = expected_out.pop_front();
                if (got !== exp_res) begin
                    if (mismatches < 10)
                        $display("mismatch: exp ch %0d y %h sat %b, got ch %0d y %h sat %b",
                                 exp_res.chan, exp_res.smp, exp_res.sat,
                                 got.chan, got.smp, got.sat);
                    mismatches++;
                end
            end
        end
        if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (sink_pause != 0) begin
            m_axis_tready <= 1'b0;
            sink_pause    <= sink_pause - 1;
        end else if (sink_steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                sink_pause    <= $urandom_range(10, 40);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (roll < 75);
            end
        end
    end

    task automatic test_order_zero_extremes();
        send_item(mk_coef(0, 0, Q24_ONE));
        send_item(mk_sample(0, 32'sh7FFF_FFFF, 0, 1'b0));
        send_item(mk_sample(0, 32'sh8000_0000, 0, 1'b0));
        send_item(mk_sample(0, 32'sh0000_0000, 0, 1'b1));
    endtask

    task automatic test_saturation();
        send_item(mk_coef(1, 0, 32'sh7FFF_FFFF));
        send_item(mk_sample(1, 32'sh7FFF_FFFF, 0, 1'b0));
        send_item(mk_sample(1, 32'sh8000_0000, 0, 1'b0));
        send_item(mk_coef(1, 0, 32'sh8000_0000));
        send_item(mk_sample(1, 32'sh8000_0000, 0, 1'b0));
        send_item(mk_sample(1, 32'sh7FFF_FFFF, 0, 1'b0));
    endtask

    task automatic test_rounding();
        send_item(mk_coef(2, 0, 32'sh0000_0001));
        send_item(mk_sample(2, 32'sh0080_0000, 0, 1'b0));
        send_item(mk_sample(2, 32'shFF80_0000, 0, 1'b0));
        send_item(mk_sample(2, 32'sh007F_FFFF, 0, 1'b0));
        send_item(mk_sample(2, 32'shFF7F_FFFF, 0, 1'b0));
    endtask

    task automatic test_history_and_order();
        send_item(mk_coef(3, 1, 32'sh0080_0000));
        send_item(mk_coef(3, 5, 32'sh0040_0000));
        send_item(mk_coef(3, 4, Q24_ONE));
        send_item(mk_coef(3, 8, 32'sh8000_0000));
        // indexes past the last a tap are dropped
        send_item(mk_coef(3, 9, 32'sh7FFF_FFFF));
        send_item(mk_coef(3, 15, 32'sh7FFF_FFFF));
        send_item(mk_sample(3, 32'sh0001_0000, 1, 1'b0));
        send_item(mk_sample(3, 32'sh0002_0000, 2, 1'b0));
        send_item(mk_sample(3, 32'shFFFF_0000, 4, 1'b0));
        send_item(mk_sample(3, 32'sh0003_0000, 7, 1'b0));
        send_item(mk_sample(3, 32'sh0001_0000, 4, 1'b1));
        send_item(mk_sample(7, 32'sh0001_8000, 5, 1'b0));
        send_item(mk_sample(7, 32'shFFFE_8000, 6, 1'b0));
    endtask

    task automatic test_random_stream(input int count);
        t_item it;
        int    roll;
        for (int k = 0; k < count; k++) begin
            src_steady  = (k >= 150 && k < 250);
            sink_steady = (k >= 300 && k < 400);
            if ($urandom_range(0, 99) < 22) begin
                roll = $urandom_range(0, 99);
                it = mk_coef($urandom_range(0, NUM_CH - 1),
                             (roll < 90) ? $urandom_range(0, NUM_TAPS - 1)
                                         : $urandom_range(NUM_TAPS, 15),
                             ($urandom_range(0, 99) < 80)
                                 ? int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000
                                 : $urandom);
            end else begin
                it = mk_sample($urandom_range(0, NUM_CH - 1),
                               ($urandom_range(0, 99) < 75)
                                   ? int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000
                                   : $urandom,
                               ($urandom_range(0, 99) < 80) ? $urandom_range(0, MAX_ORD)
                                                            : $urandom_range(0, 7),
                               ($urandom_range(0, 99) < 8));
            end
            send_item(it);
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        src_steady = 1'b1;
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        for (int k = 0; k < 20; k++)
            send_item(mk_sample($urandom_range(0, NUM_CH - 1), $urandom,
                                $urandom_range(0, 7), 1'($urandom_range(0, 1))));
        src_steady = 1'b0;
    endtask

    initial begin
        for (int c = 0; c < NUM_CH; c++) begin
            for (int t = 0; t < NUM_TAPS; t++) coef_mem[c][t] = '0;
            for (int h = 0; h < MAX_ORD; h++) begin
                x_hist[c][h] = '0;
                y_hist[c][h] = '0;
            end
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_order_zero_extremes();
        test_saturation();
        test_rounding();
        test_history_and_order();
        test_random_stream(500);
        test_backpressure();
        s_axis_tvalid <= 1'b0;

        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("covered %0d sample and %0d coefficient transactions on %0d channels",
                 n_samples, n_coef, NUM_CH);
        $display("checked %0d outputs, %0d saturated, %0d mismatches",
                 n_checked, n_sat, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
